// File: sv/glyph_bitmap_pixel_expander_defines.svh
// ============================================================================
// Glyph bitmap pixel expander assertion macros
// Shared property wrappers for the concurrent checks on the expander.
// ============================================================================
`ifndef GLYPH_BITMAP_PIXEL_EXPANDER_DEFINES_SVH
`define GLYPH_BITMAP_PIXEL_EXPANDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define GBPE_ASSERT_NOW(label, clk, dis, pre, post) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
        else $error("gbpe: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define GBPE_ASSERT_NEXT(label, clk, dis, pre, post) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
        else $error("gbpe: next-cycle check failed");

`endif

// File: sv/gbpe_pkg.sv
// ============================================================================
// Glyph bitmap pixel expander package
// Shared types and constants for the front end, job queue and back end.
// ============================================================================
package gbpe_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GLYPH_WIDTH  = 3'd0,
        CFG_GLYPH_HEIGHT = 3'd1,
        CFG_FG_COLOR     = 3'd2,
        CFG_BG_COLOR     = 3'd3,
        CFG_COLOR_MODE   = 3'd4,
        CFG_ALIGNMENT    = 3'd5
    } cfg_index_t;

    localparam int CFG_DATA_W = 18;
    localparam int WIDTH_W    = 6;
    localparam int HEIGHT_W   = 7;
    localparam int COLOR_W    = 18;

    // Color mode encodings.
    localparam logic MODE_65K  = 1'b0;
    localparam logic MODE_262K = 1'b1;

    // Job queue geometry.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // One classified font byte, ready for pixel expansion.
    typedef struct packed {
        logic [7:0] font_byte;
        logic [2:0] first_bit;   // bit offset from the MSB of the first pixel
        logic [3:0] npix;        // pixels to emit, 1..8
        logic       glyph_end;   // final pixel of this job ends the glyph
    } job_t;

endpackage

// File: sv/glyph_bitmap_pixel_expander.sv
// Glyph bitmap pixel expander. Font bitmap bytes enter on the s_ stream and leave as 16-bit
// display bus words on the m_ stream, one word per cycle while the receiver is ready: a byte
// yields up to eight pixels, one word each in 65K mode and two in 262K mode, so a full byte
// gives 8 or 16 words. The front end classifies a byte in the cycle it is accepted and queues
// the job in a four-entry queue; input requests are taken every cycle while the queue has
// room, so the sustained rate is set by the single-word-per-cycle output stage. Bytes
// after the end of a glyph give no words. Configuration is written through cfg_we,
// cfg_index and cfg_wdata and must only change while the block is idle.
// ============================================================================
// Glyph bitmap pixel expander top level
// Configuration registers, front end, job queue and back end.
// ============================================================================
module glyph_bitmap_pixel_expander
    import gbpe_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] font_byte
    input  logic                  s_tuser,   // [0] glyph_start
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] bus_word
    output logic [1:0]            m_tuser,   // [0] is_foreground, [1] end_of_glyph
    output logic                  m_tlast,   // last word of this font byte
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [WIDTH_W-1:0]  glyph_width_reg;
    logic [HEIGHT_W-1:0] glyph_height_reg;
    logic [COLOR_W-1:0]  fg_color_reg;
    logic [COLOR_W-1:0]  bg_color_reg;
    logic                color_mode_reg;
    logic                alignment_reg;

    logic q_push, q_full, q_pop, q_empty;
    job_t q_push_job, q_pop_job;
    logic s_accept;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_width_reg  <= WIDTH_W'(8);
            glyph_height_reg <= HEIGHT_W'(16);
            fg_color_reg     <= '1;
            bg_color_reg     <= '0;
            color_mode_reg   <= MODE_262K;
            alignment_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_FG_COLOR:     fg_color_reg     <= cfg_wdata[COLOR_W-1:0];
                CFG_BG_COLOR:     bg_color_reg     <= cfg_wdata[COLOR_W-1:0];
                CFG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[0];
                CFG_ALIGNMENT:    alignment_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input requests are taken whenever the job queue has room.
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    gbpe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .font_byte    (s_tdata),
        .glyph_start  (s_tuser),
        .glyph_width  (glyph_width_reg),
        .glyph_height (glyph_height_reg),
        .alignment    (alignment_reg),
        .push         (q_push),
        .push_job     (q_push_job)
    );

    gbpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    gbpe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_job      (q_pop_job),
        .q_pop      (q_pop),
        .fg_color   (fg_color_reg),
        .bg_color   (bg_color_reg),
        .color_mode (color_mode_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_word     (m_tdata),
        .m_fg       (m_tuser[0]),
        .m_eog      (m_tuser[1]),
        .m_last     (m_tlast)
    );

endmodule

// File: sv/gbpe_queue.sv
// ============================================================================
// Glyph expander job queue
// Small first-in first-out queue that decouples the front end from the back end.
// ============================================================================
module gbpe_queue
    import gbpe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t             mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: sv/gbpe_front.sv
// ============================================================================
// Glyph expander front end
// Tracks row and column, classifies font bytes and queues in-glyph pixel jobs.
// ============================================================================
module gbpe_front
    import gbpe_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          font_byte,
    input  logic                glyph_start,
    input  logic [WIDTH_W-1:0]  glyph_width,
    input  logic [HEIGHT_W-1:0] glyph_height,
    input  logic                alignment,
    output logic                push,
    output job_t                push_job
);

    localparam logic [WIDTH_W:0]  MaxW = (WIDTH_W+1)'(MAX_WIDTH);
    localparam logic [HEIGHT_W:0] MaxH = (HEIGHT_W+1)'(MAX_HEIGHT);

    logic [WIDTH_W-1:0]  col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic                done_reg, done_next;

    logic [WIDTH_W:0]    w_ext;
    logic [HEIGHT_W:0]   h_ext;
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    logic [2:0]          pad;
    logic [WIDTH_W-1:0]  col_s, col_e, remain;
    logic [HEIGHT_W-1:0] row_s;
    logic                done_s;
    logic [3:0]          n8;
    logic [3:0]          n;
    logic [2:0]          first_bit;
    logic                row_end, glyph_end;

    // Effective geometry: zero acts as one, oversize clamps to the maximum.
    always_comb begin
        w_ext = {1'b0, glyph_width};
        if (glyph_width == '0) begin
            w_ext = (WIDTH_W+1)'(1);
        end else if (w_ext > MaxW) begin
            w_ext = MaxW;
        end
        h_ext = {1'b0, glyph_height};
        if (glyph_height == '0) begin
            h_ext = (HEIGHT_W+1)'(1);
        end else if (h_ext > MaxH) begin
            h_ext = MaxH;
        end
        w   = w_ext[WIDTH_W-1:0];
        h   = h_ext[HEIGHT_W-1:0];
        pad = 3'(4'd8 - {1'b0, w[2:0]});
    end

    // Classify the byte and work out the position after it.
    always_comb begin
        col_s     = glyph_start ? '0 : col_reg;
        row_s     = glyph_start ? '0 : row_reg;
        done_s    = glyph_start ? 1'b0 : done_reg;
        col_e     = (col_s >= w) ? '0 : col_s;
        remain    = w - col_e;
        first_bit = 3'd0;
        n8        = 4'd8;
        if (alignment && (col_e == '0)) begin
            first_bit = pad;
            n8        = 4'd8 - {1'b0, pad};
        end
        n         = ({2'b00, n8} > remain) ? remain[3:0] : n8;
        row_end   = (({1'b0, col_e} + {3'b000, n}) >= {1'b0, w});
        glyph_end = row_end && (({1'b0, row_s} + 1'b1) >= {1'b0, h});

        push      = 1'b0;
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        if (accept) begin
            priority if (done_s) begin
                col_next  = col_s;
                row_next  = row_s;
                done_next = 1'b1;
            end else if (row_s >= h) begin
                // Height shrank below the current row: the glyph is complete.
                col_next  = col_s;
                row_next  = row_s;
                done_next = 1'b1;
            end else begin
                push = 1'b1;
                if (row_end) begin
                    col_next  = '0;
                    row_next  = row_s + 1'b1;
                    done_next = glyph_end;
                end else begin
                    col_next  = col_e + {2'b00, n};
                    row_next  = row_s;
                    done_next = 1'b0;
                end
            end
        end

        push_job.font_byte = font_byte;
        push_job.first_bit = first_bit;
        push_job.npix      = n;
        push_job.glyph_end = glyph_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            done_reg <= done_next;
        end
    end

endmodule

// File: sv/gbpe_back.sv
// ============================================================================
// Glyph expander back end
// Expands jobs into registered bus words, one per cycle unless output stalls.
// ============================================================================
module gbpe_back
    import gbpe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  job_t               q_job,
    output logic               q_pop,
    input  logic [COLOR_W-1:0] fg_color,
    input  logic [COLOR_W-1:0] bg_color,
    input  logic               color_mode,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_word,
    output logic               m_fg,
    output logic               m_eog,
    output logic               m_last
);

    logic        busy_reg, busy_next;
    logic [7:0]  bits_reg, bits_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        half_reg, half_next;
    logic        gend_reg, gend_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] word_reg;
    logic        fg_reg, eog_reg, last_reg;

    logic               adv;
    logic               pix_bit;
    logic [COLOR_W-1:0] color;
    logic               last_word;
    logic [15:0]        word_val;

    // Current pixel and the word it produces now.
    always_comb begin
        adv     = busy_reg && (!out_valid_reg || m_ready);
        pix_bit = bits_reg[7];
        color   = pix_bit ? fg_color : bg_color;
        if (color_mode == MODE_65K) begin
            word_val  = color[15:0];
            last_word = (cnt_reg == 4'd1);
        end else if (!half_reg) begin
            word_val  = {color[17:12], 2'b00, color[11:6], 2'b00};
            last_word = 1'b0;
        end else begin
            word_val  = {8'h00, color[5:0], 2'b00};
            last_word = (cnt_reg == 4'd1);
        end
        q_pop = !q_empty && (!busy_reg || (adv && last_word));
    end

    // Job sequencing: step through pixels, load the next job when done.
    always_comb begin
        busy_next = busy_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        half_next = half_reg;
        gend_next = gend_reg;
        if (adv) begin
            if ((color_mode == MODE_262K) && !half_reg) begin
                half_next = 1'b1;
            end else begin
                half_next = 1'b0;
                cnt_next  = cnt_reg - 1'b1;
                bits_next = {bits_reg[6:0], 1'b0};
                if (cnt_reg == 4'd1) begin
                    busy_next = 1'b0;
                end
            end
        end
        if (q_pop) begin
            busy_next = 1'b1;
            bits_next = q_job.font_byte << q_job.first_bit;
            cnt_next  = q_job.npix;
            half_next = 1'b0;
            gend_next = q_job.glyph_end;
        end
        out_valid_next = adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        cnt_reg  <= cnt_next;
        gend_reg <= gend_next;
        if (adv) begin
            word_reg <= word_val;
            fg_reg   <= pix_bit;
            last_reg <= last_word;
            eog_reg  <= last_word && gend_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = word_reg;
    assign m_fg    = fg_reg;
    assign m_eog   = eog_reg;
    assign m_last  = last_reg;

endmodule

// File: sv/gbpe_checker.sv
// ============================================================================
// Glyph expander port checker
// Concurrent checks on the top-level ports, bound to the expander.
// ============================================================================
`include "glyph_bitmap_pixel_expander_defines.svh"

module gbpe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic        out_stall;
    logic [18:0] out_payload;

    // Output request waiting for the receiver, and everything it carries.
    assign out_stall   = m_tvalid && !m_tready;
    assign out_payload = {m_tlast, m_tuser, m_tdata};

    // A stalled output request keeps its word.
    `GBPE_ASSERT_NEXT(a_out_hold, aclk, !aresetn, out_stall, m_tvalid && $stable(out_payload))

    // The final word of a glyph is always the last word of its font byte.
    `GBPE_ASSERT_NOW(a_eog_is_last, aclk, !aresetn, m_tvalid && m_tuser[1], m_tlast)

    // Reset empties the output register.
    `GBPE_ASSERT_NEXT(a_reset_clears, aclk, 1'b0, !aresetn, !m_tvalid)

endmodule

bind glyph_bitmap_pixel_expander gbpe_checker u_gbpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/glyph_bitmap_pixel_expander_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Glyph bitmap pixel expander testbench
// Streams font bitmap bytes into the expander under several register settings
// and checks every bus word against a cycle-free model of the pixel expansion.
// ============================================================================
module glyph_bitmap_pixel_expander_tb;
    import gbpe_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int MAX_W        = 32;
    localparam int MAX_H        = 64;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;

    // One font byte request and one expected bus word.
    typedef struct {
        logic [7:0] font_byte;
        logic       glyph_start;
    } font_req_t;

    typedef struct {
        logic [15:0] bus_word;
        logic        is_fg;
        logic        glyph_end;
        logic        byte_last;
    } pixel_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] font_byte
    logic                  s_tuser   = 1'b0; // [0] glyph_start
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // [15:0] bus_word
    logic [1:0]            m_tuser;          // [0] is_foreground, [1] end_of_glyph
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Expansion model: register copies and glyph position, at reset values.
    logic [5:0]  width_reg  = 6'd8;
    logic [6:0]  height_reg = 7'd16;
    logic [17:0] fg_reg     = 18'h3FFFF;
    logic [17:0] bg_reg     = 18'h0;
    logic        mode_reg   = MODE_262K;
    logic        align_reg  = 1'b0;
    logic [5:0]  col_pos    = '0;
    logic [6:0]  row_pos    = '0;
    logic        glyph_done = 1'b0;

    font_req_t   pending_bytes[$];
    pixel_word_t expected_words[$];

    int  src_idle_pct = 15;
    int  dst_idle_pct = 86;
    int  holds_asked  = 0;
    int  holds_served = 0;
    int  hold_left    = 0;
    bit  byte_taken   = 1'b0;
    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  bytes_taken  = 0;
    int  words_checked = 0;
    int  reg_writes   = 0;
    int  stall_cycles = 0;

    glyph_bitmap_pixel_expander #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // A zero size acts as one, anything above the maximum as the maximum.
    function automatic int clamp_dim(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Expand one accepted font byte into the bus words it must produce.
    function automatic void expand_font_byte(logic [7:0] fb, logic start);
        int          w;
        int          h;
        int          pad;
        int          first_bit;
        int          npix;
        int          bitpos;
        logic        px;
        logic        final_px;
        logic        row_end;
        logic        glyph_end;
        logic [17:0] color;
        pixel_word_t word;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        pad = (8 - (w % 8)) % 8;
        first_bit = 0;
        if (start) begin
            col_pos = '0;
            row_pos = '0;
            glyph_done = 1'b0;
        end
        if (glyph_done) return;
        // A height lowered under the current row ends the glyph silently.
        if (row_pos >= h) begin
            glyph_done = 1'b1;
            return;
        end
        // A width lowered under the current column restarts the row.
        if (col_pos >= w) col_pos = '0;

        npix = 8;
        if (align_reg && col_pos == 0) begin
            first_bit = pad;
            npix = 8 - pad;
        end
        if (npix > w - col_pos) npix = w - col_pos;
        row_end = (col_pos + npix >= w);
        glyph_end = row_end && (row_pos + 1 >= h);

        for (int i = 0; i < npix; i++) begin
            bitpos = 7 - (first_bit + i);
            px = fb[bitpos];
            color = px ? fg_reg : bg_reg;
            final_px = (i + 1 == npix);
            word.is_fg = px;
            if (mode_reg == MODE_65K) begin
                word.bus_word = color[15:0];
                word.glyph_end = final_px && glyph_end;
                word.byte_last = final_px;
                expected_words.push_back(word);
            end else begin
                // RGB666 split over two words: red and green first, then blue.
                word.bus_word = {color[17:12], 2'b00, color[11:6], 2'b00};
                word.glyph_end = 1'b0;
                word.byte_last = 1'b0;
                expected_words.push_back(word);
                word.bus_word = {8'h00, color[5:0], 2'b00};
                word.glyph_end = final_px && glyph_end;
                word.byte_last = final_px;
                expected_words.push_back(word);
            end
        end

        if (row_end) begin
            col_pos = '0;
            row_pos = row_pos + 7'd1;
            if (glyph_end) glyph_done = 1'b1;
        end else begin
            col_pos = col_pos + 6'(npix);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at word %0d: %s = 0x%0h, expected 0x%0h",
                 words_checked, what, got, want);
        mismatches++;
    endtask

    // Accepted input requests feed the model; input stalls are counted.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid) begin
            if (s_tready) begin
                expand_font_byte(s_tdata, s_tuser);
                bytes_taken++;
                byte_taken = 1'b1;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Sender: offers the next pending byte, idling at random between requests.
    always @(negedge aclk) begin
        font_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            byte_taken = 1'b0;
            if (pending_bytes.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                req = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= req.font_byte;
                s_tuser  <= req.glyph_start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure, plus long hold-offs on request.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_asked != holds_served) begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= dst_idle_pct);
        end
    end

    // Monitor: compare each output word with the oldest expectation.
    always @(posedge aclk) begin
        pixel_word_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("[glyph_bitmap_pixel_expander] ERROR");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected bus_word", m_tdata, 0);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want.bus_word)
                    report_mismatch("bus_word", m_tdata, want.bus_word);
                if (m_tuser[0] !== want.is_fg)
                    report_mismatch("is_foreground", m_tuser[0], want.is_fg);
                if (m_tuser[1] !== want.glyph_end)
                    report_mismatch("end_of_glyph", m_tuser[1], want.glyph_end);
                if (m_tlast !== want.byte_last)
                    report_mismatch("last", m_tlast, want.byte_last);
            end
            words_checked++;
        end
    end

    task automatic add_byte(logic [7:0] fb, logic start);
        font_req_t req;
        req.font_byte = fb;
        req.glyph_start = start;
        pending_bytes.push_back(req);
    endtask

    // Write one register and mirror it into the model.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        unique case (idx)
            CFG_GLYPH_WIDTH:  width_reg  = val[5:0];
            CFG_GLYPH_HEIGHT: height_reg = val[6:0];
            CFG_FG_COLOR:     fg_reg     = val[17:0];
            CFG_BG_COLOR:     bg_reg     = val[17:0];
            CFG_COLOR_MODE:   mode_reg   = val[0];
            CFG_ALIGNMENT:    align_reg  = val[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int w, int h, int fg, int bg, int mode, int align);
        write_reg(CFG_GLYPH_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_GLYPH_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_FG_COLOR, CFG_DATA_W'(fg));
        write_reg(CFG_BG_COLOR, CFG_DATA_W'(bg));
        write_reg(CFG_COLOR_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_ALIGNMENT, CFG_DATA_W'(align));
    endtask

    // Wait until every byte is taken and every word has come out, then let
    // the pipeline settle so that bytes without words have passed as well.
    task automatic wait_idle();
        while (pending_bytes.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly whole glyphs with random content; some are cut short by a new
    // start, and some are followed by stray bytes, which give no words after a whole glyph.
    task automatic add_glyphs(int budget);
        int added;
        int per_glyph;
        int nbytes;
        int w;
        added = 0;
        w = clamp_dim(width_reg, MAX_W);
        per_glyph = clamp_dim(height_reg, MAX_H) * ((w + 7) / 8);
        while (added < budget) begin
            if ($urandom_range(99, 0) < 85) nbytes = per_glyph;
            else nbytes = $urandom_range(per_glyph, 1);
            for (int k = 0; k < nbytes; k++) add_byte(8'($urandom_range(255, 0)), k == 0);
            added += nbytes;
            if ($urandom_range(99, 0) < 25)
                repeat ($urandom_range(2, 1)) add_byte(8'($urandom_range(255, 0)), 1'b0);
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings; the very first byte has no start flag.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h5A, 1'b0);
        wait_idle();

        // Zero sizes act as a single pixel; 65K mode drops the high color bits.
        // Bytes after a finished glyph give nothing until the next start.
        set_config(0, 0, 18'h3ABCD, 18'h15432, MODE_65K, 1'b0);
        add_byte(8'h80, 1'b1);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        wait_idle();

        // Width lowered below the current column: the byte starts a fresh row.
        set_config(12, 2, 18'h2AAAA, 18'h15555, MODE_262K, 1'b0);
        add_byte(8'hC3, 1'b1);
        wait_idle();
        write_reg(CFG_GLYPH_WIDTH, CFG_DATA_W'(5));
        add_byte(8'h96, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h0F, 1'b0);
        wait_idle();

        // Height lowered below the current row: the glyph is over, silently.
        set_config(8, 4, 18'h3F000, 18'h00FC0, MODE_65K, 1'b1);
        add_byte(8'hA5, 1'b1);
        add_byte(8'h3C, 1'b0);
        add_byte(8'hE7, 1'b0);
        wait_idle();
        write_reg(CFG_GLYPH_HEIGHT, CFG_DATA_W'(2));
        add_byte(8'hFF, 1'b0);
        add_byte(8'h81, 1'b0);
        add_byte(8'h3C, 1'b1);
        wait_idle();

        // Right aligned narrow row: the leading padding bits are skipped.
        set_config(3, 1, 18'h0003F, 18'h3FFC0, MODE_262K, 1'b1);
        add_byte(8'hFD, 1'b1);
        add_byte(8'h02, 1'b1);
        wait_idle();

        // Random glyphs, receiver mostly stalled.
        set_config($urandom_range(16, 9), $urandom_range(4, 1), $urandom_range(262143, 0),
                   $urandom_range(262143, 0), MODE_65K, 1'b1);
        add_glyphs(12);
        wait_idle();
        set_config(63, 2, 18'h3FFFF, 18'h0, MODE_262K, 1'b1);
        add_glyphs(16);
        wait_idle();

        // Sender mostly idle.
        src_idle_pct = 86;
        dst_idle_pct = 15;
        set_config(1, 127, 18'h0, 18'h3FFFF, MODE_65K, 1'b0);
        add_glyphs(40);
        wait_idle();
        set_config($urandom_range(32, 1), $urandom_range(3, 1), $urandom_range(262143, 0),
                   $urandom_range(262143, 0), $urandom_range(1, 0), $urandom_range(1, 0));
        add_glyphs(12);
        wait_idle();

        // No idling on either side, with one long output hold-off so the
        // job queue fills and the input has to stall.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_config($urandom_range(32, 1), $urandom_range(3, 1), $urandom_range(262143, 0),
                   $urandom_range(262143, 0), $urandom_range(1, 0), $urandom_range(1, 0));
        holds_asked++;
        add_glyphs(12);
        wait_idle();

        $display("Checked %0d bus words from %0d font bytes after %0d register writes.",
                 words_checked, bytes_taken, reg_writes);
        $display("Input was held back for %0d cycles by output backpressure.", stall_cycles);
        if (mismatches == 0) begin
            $display("[glyph_bitmap_pixel_expander] OK");
        end else begin
            $display("[glyph_bitmap_pixel_expander] ERROR");
        end
        $finish;
    end

endmodule
